// ----- rtl/metab_pkg.sv -----
// Package: shared types and constants for the mesh edge use table.
`timescale 1ns / 1ps
package metab_pkg;
   localparam int MAX_VERTICES_DEF = 65536;
   localparam int EDGE_SLOTS_DEF   = 1024;
   localparam int VERTEX_W         = 16;
   localparam int USES_W           = 16;
   localparam int UNIQUE_W         = 11;
   localparam int FACE_EDGES       = 3;
   localparam logic [USES_W-1:0] USE_MAX = '1;

   typedef struct packed {
      logic [VERTEX_W-1:0] vertex_a;
      logic [VERTEX_W-1:0] vertex_b;
      logic [VERTEX_W-1:0] vertex_c;
      logic                last_face;
   } face_type;

   typedef struct packed {
      logic [UNIQUE_W-1:0] unique_edges;
      logic [2:0]          new_edge_mask;
      logic [USES_W-1:0]   uses_ab;
      logic [USES_W-1:0]   uses_bc;
      logic [USES_W-1:0]   uses_ca;
      logic                table_full;
      logic                mesh_done;
   } result_type;
endpackage

// ----- rtl/mesh_edge_use_table.sv -----
// Top level: triangle edge use counter with intake queue and table engine.
//  channel | direction | handshake      | payload
//  req_    | in        | push / full    | vertex_a, vertex_b, vertex_c, last_face
//  rsp_    | out       | empty / pop    | unique_edges .. mesh_done
// Per edge the engine searches the stored edges in order through the RAM read port,
// one entry at a time, then updates the match or appends the edge if a slot is free.
// Reset is synchronous; the stored-edge count clears, table contents need no clearing.
// Two faces queue ahead of the engine; the engine stalls in its output state only
// while the previous result still waits in the output register.
`timescale 1ns / 1ps
module mesh_edge_use_table #(
   parameter int MAX_VERTICES = metab_pkg::MAX_VERTICES_DEF,
   parameter int EDGE_SLOTS   = metab_pkg::EDGE_SLOTS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   output logic                              full,
   input  logic [metab_pkg::VERTEX_W-1:0]    req_vertex_a,
   input  logic [metab_pkg::VERTEX_W-1:0]    req_vertex_b,
   input  logic [metab_pkg::VERTEX_W-1:0]    req_vertex_c,
   input  logic                              req_last_face,
   output logic                              empty,
   input  logic                              pop,
   output logic [metab_pkg::UNIQUE_W-1:0]    rsp_unique_edges,
   output logic [2:0]                        rsp_new_edge_mask,
   output logic [metab_pkg::USES_W-1:0]      rsp_uses_ab,
   output logic [metab_pkg::USES_W-1:0]      rsp_uses_bc,
   output logic [metab_pkg::USES_W-1:0]      rsp_uses_ca,
   output logic                              rsp_table_full,
   output logic                              rsp_mesh_done
);
   import metab_pkg::*;

   face_type   face, q_face;
   result_type rsp;
   logic       q_valid, q_take;

   assign face = '{vertex_a: req_vertex_a, vertex_b: req_vertex_b,
                   vertex_c: req_vertex_c, last_face: req_last_face};

   metab_front u_front (
      .clock, .reset, .push, .full, .face, .q_valid, .q_take, .q_face);

   metab_back #(.MAX_VERTICES(MAX_VERTICES), .EDGE_SLOTS(EDGE_SLOTS)) u_back (
      .clock, .reset, .q_valid, .q_take, .q_face,
      .rsp_empty(empty), .rsp_pop(pop), .rsp);

   assign rsp_unique_edges  = rsp.unique_edges;
   assign rsp_new_edge_mask = rsp.new_edge_mask;
   assign rsp_uses_ab       = rsp.uses_ab;
   assign rsp_uses_bc       = rsp.uses_bc;
   assign rsp_uses_ca       = rsp.uses_ca;
   assign rsp_table_full    = rsp.table_full;
   assign rsp_mesh_done     = rsp.mesh_done;
endmodule

// ----- rtl/metab_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module metab_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- rtl/metab_front.sv -----
// Front end: face intake queue of two entries.
`timescale 1ns / 1ps
module metab_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  metab_pkg::face_type face,
   output logic                q_valid,
   input  logic                q_take,
   output metab_pkg::face_type q_face
);
   import metab_pkg::*;

   face_type   slot_ff [2];
   logic       wptr_ff, rptr_ff;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full    = cnt_ff == 2'd2;
   assign q_valid = cnt_ff != 2'd0;
   assign q_face  = slot_ff[rptr_ff];
   assign do_push = push && !full;
   assign do_pop  = q_take && q_valid;

   always_comb begin
      cnt_in = cnt_ff;
      if (do_push && !do_pop) cnt_in = cnt_ff + 2'd1;
      else if (!do_push && do_pop) cnt_in = cnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         if (do_push) wptr_ff <= ~wptr_ff;
         if (do_pop) rptr_ff <= ~rptr_ff;
      end
      if (do_push) slot_ff[wptr_ff] <= face;
   end
endmodule

// ----- rtl/metab_back.sv -----
// Back end: sequential edge search, update and append over the edge table.
`timescale 1ns / 1ps
module metab_back #(
   parameter int MAX_VERTICES = metab_pkg::MAX_VERTICES_DEF,
   parameter int EDGE_SLOTS   = metab_pkg::EDGE_SLOTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_take,
   input  metab_pkg::face_type   q_face,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output metab_pkg::result_type rsp
);
   import metab_pkg::*;

   localparam int AW = $clog2(EDGE_SLOTS);
   localparam int CW = $clog2(EDGE_SLOTS + 1);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_EDGE  = 6'b000010,
      S_READ  = 6'b000100,
      S_CMP   = 6'b001000,
      S_WRITE = 6'b010000,
      S_OUT   = 6'b100000
   } state_type;

   state_type            state_ff;
   face_type             face_ff;
   logic [1:0]           k_ff;
   logic [VERTEX_W-1:0]  lo_ff, hi_ff;
   logic [CW-1:0]        count_ff, idx_ff;
   logic [2:0]           mask_ff;
   logic                 full_ff;
   logic [USES_W-1:0]    uses_ff [FACE_EDGES];
   logic                 hit_ff;
   logic [USES_W-1:0]    nuse_ff;
   result_type           rsp_ff;
   logic                 rsp_valid_ff;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr, rd_addr;
   logic [VERTEX_W-1:0]  rd_lo, rd_hi;
   logic [USES_W-1:0]    rd_use, wr_use;
   logic [VERTEX_W-1:0]  p, q;
   logic                 in_range;
   logic                 out_fire;

   assign q_take    = state_ff == S_IDLE;
   assign rsp_empty = !rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign rd_addr   = idx_ff[AW-1:0];
   assign wr_use    = nuse_ff;
   assign out_fire  = state_ff == S_OUT && (!rsp_valid_ff || rsp_pop);

   always_comb begin
      case (k_ff)
         2'd0:    begin p = face_ff.vertex_a; q = face_ff.vertex_b; end
         2'd1:    begin p = face_ff.vertex_b; q = face_ff.vertex_c; end
         default: begin p = face_ff.vertex_c; q = face_ff.vertex_a; end
      endcase
      in_range = (32'(p) < 32'(MAX_VERTICES)) && (32'(q) < 32'(MAX_VERTICES));
   end

   always_comb begin
      wr_en   = state_ff == S_WRITE;
      wr_addr = hit_ff ? idx_ff[AW-1:0] : count_ff[AW-1:0];
   end

   metab_ram #(.WIDTH(VERTEX_W), .DEPTH(EDGE_SLOTS)) u_lo (
      .clock, .wr_en, .wr_addr, .wr_data(lo_ff), .rd_addr, .rd_data(rd_lo));
   metab_ram #(.WIDTH(VERTEX_W), .DEPTH(EDGE_SLOTS)) u_hi (
      .clock, .wr_en, .wr_addr, .wr_data(hi_ff), .rd_addr, .rd_data(rd_hi));
   metab_ram #(.WIDTH(USES_W), .DEPTH(EDGE_SLOTS)) u_use (
      .clock, .wr_en, .wr_addr, .wr_data(wr_use), .rd_addr, .rd_data(rd_use));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (out_fire) rsp_valid_ff <= 1'b1;
         else if (rsp_pop && rsp_valid_ff) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (q_valid) begin
               face_ff  <= q_face;
               k_ff     <= 2'd0;
               mask_ff  <= '0;
               full_ff  <= 1'b0;
               state_ff <= S_EDGE;
            end
            S_EDGE: begin
               lo_ff  <= (p < q) ? p : q;
               hi_ff  <= (p < q) ? q : p;
               idx_ff <= '0;
               hit_ff <= 1'b0;
               uses_ff[k_ff] <= '0;
               if (!in_range) begin
                  if (k_ff == 2'd2) state_ff <= S_OUT;
                  else k_ff <= k_ff + 2'd1;
               end else begin
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               if (idx_ff < count_ff) state_ff <= S_CMP;
               else if (count_ff >= CW'(EDGE_SLOTS)) begin
                  full_ff <= 1'b1;
                  state_ff <= (k_ff == 2'd2) ? S_OUT : S_EDGE;
                  if (k_ff != 2'd2) k_ff <= k_ff + 2'd1;
               end else begin
                  nuse_ff  <= USES_W'(1);
                  state_ff <= S_WRITE;
               end
            end
            S_CMP: begin
               if (rd_lo == lo_ff && rd_hi == hi_ff) begin
                  hit_ff   <= 1'b1;
                  nuse_ff  <= (rd_use == USE_MAX) ? rd_use : rd_use + USES_W'(1);
                  state_ff <= S_WRITE;
               end else begin
                  idx_ff   <= idx_ff + CW'(1);
                  state_ff <= S_READ;
               end
            end
            S_WRITE: begin
               uses_ff[k_ff] <= nuse_ff;
               if (!hit_ff) begin
                  count_ff <= count_ff + CW'(1);
                  mask_ff[k_ff] <= 1'b1;
               end
               if (k_ff == 2'd2) state_ff <= S_OUT;
               else begin
                  k_ff <= k_ff + 2'd1;
                  state_ff <= S_EDGE;
               end
            end
            S_OUT: if (out_fire) begin
               rsp_ff.unique_edges  <= UNIQUE_W'(count_ff);
               rsp_ff.new_edge_mask <= mask_ff;
               rsp_ff.uses_ab       <= uses_ff[0];
               rsp_ff.uses_bc       <= uses_ff[1];
               rsp_ff.uses_ca       <= uses_ff[2];
               rsp_ff.table_full    <= full_ff;
               rsp_ff.mesh_done     <= face_ff.last_face;
               if (face_ff.last_face) count_ff <= '0;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ----- rtl/metab_checker.sv -----
// Checker on the top-level ports, bound to the top level.
`timescale 1ns / 1ps
module metab_checker (
   input logic        clock,
   input logic        reset,
   input logic        push,
   input logic        full,
   input logic        empty,
   input logic        pop,
   input logic [2:0]  rsp_new_edge_mask,
   input logic        rsp_table_full,
   input logic [15:0] rsp_uses_ab
);
   a_reset_empty: assert property (@(posedge clock) reset |=> empty && !full)
      else $error("not empty after reset");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_new_edge_mask))
      else $error("result changed while waiting");
   a_mask_uses: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_new_edge_mask[0] |-> rsp_uses_ab == 16'd1)
      else $error("new edge without count of one");
   a_full_mask: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_new_edge_mask == 3'b111 |-> !rsp_table_full)
      else $error("full with all edges added");
   a_flag_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> $stable(rsp_table_full) && $stable(rsp_uses_ab))
      else $error("waiting beat changed");
endmodule

bind mesh_edge_use_table metab_checker u_metab_checker (
   .clock, .reset, .push, .full, .empty, .pop,
   .rsp_new_edge_mask, .rsp_table_full, .rsp_uses_ab);

// ----- tb/sv/tb_mesh_edge_use_table.sv -----
// Testbench for mesh_edge_use_table: face stimulus, edge tally prediction, result checks.
`timescale 1ns / 1ps
module tb_mesh_edge_use_table;
   import metab_pkg::*;

   localparam int SLOTS       = EDGE_SLOTS_DEF;
   localparam int STALL_LIMIT = 100000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                push  = 1'b0;
   logic                full;
   logic [VERTEX_W-1:0] req_vertex_a = '0;
   logic [VERTEX_W-1:0] req_vertex_b = '0;
   logic [VERTEX_W-1:0] req_vertex_c = '0;
   logic                req_last_face = 1'b0;
   logic                empty;
   logic                pop = 1'b0;
   logic [UNIQUE_W-1:0] rsp_unique_edges;
   logic [2:0]          rsp_new_edge_mask;
   logic [USES_W-1:0]   rsp_uses_ab;
   logic [USES_W-1:0]   rsp_uses_bc;
   logic [USES_W-1:0]   rsp_uses_ca;
   logic                rsp_table_full;
   logic                rsp_mesh_done;

   // predictor copy of the edge table
   logic [VERTEX_W-1:0] tbl_lo   [SLOTS];
   logic [VERTEX_W-1:0] tbl_hi   [SLOTS];
   logic [USES_W-1:0]   tbl_uses [SLOTS];
   int                  edge_count = 0;

   result_type pending_tallies[$];
   int         errors       = 0;
   bit         calm         = 1'b0;
   int         hold_cycles  = 0;
   int         quiet_cycles = 0;

   mesh_edge_use_table dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_vertex_a(req_vertex_a), .req_vertex_b(req_vertex_b),
      .req_vertex_c(req_vertex_c), .req_last_face(req_last_face),
      .empty(empty), .pop(pop),
      .rsp_unique_edges(rsp_unique_edges), .rsp_new_edge_mask(rsp_new_edge_mask),
      .rsp_uses_ab(rsp_uses_ab), .rsp_uses_bc(rsp_uses_bc), .rsp_uses_ca(rsp_uses_ca),
      .rsp_table_full(rsp_table_full), .rsp_mesh_done(rsp_mesh_done)
   );

   always #10 clock = ~clock;

   function automatic result_type tally_face(face_type f);
      logic [VERTEX_W-1:0] v [FACE_EDGES];
      logic [VERTEX_W-1:0] lo, hi;
      logic [USES_W-1:0]   u;
      result_type          r;
      bit                  hit;
      int                  k, i;
      r = '0;
      v[0] = f.vertex_a;
      v[1] = f.vertex_b;
      v[2] = f.vertex_c;
      for (k = 0; k < FACE_EDGES; k++) begin
         lo  = (v[k] < v[(k+1)%FACE_EDGES]) ? v[k] : v[(k+1)%FACE_EDGES];
         hi  = (v[k] < v[(k+1)%FACE_EDGES]) ? v[(k+1)%FACE_EDGES] : v[k];
         hit = 1'b0;
         u   = '0;
         for (i = 0; i < edge_count && !hit; i++) begin
            if (tbl_lo[i] == lo && tbl_hi[i] == hi) begin
               hit = 1'b1;
               if (tbl_uses[i] != USE_MAX) tbl_uses[i] = tbl_uses[i] + USES_W'(1);
               u = tbl_uses[i];
            end
         end
         if (!hit) begin
            if (edge_count >= SLOTS) begin
               r.table_full = 1'b1;
            end else begin
               tbl_lo[edge_count]   = lo;
               tbl_hi[edge_count]   = hi;
               tbl_uses[edge_count] = USES_W'(1);
               edge_count++;
               u = USES_W'(1);
               r.new_edge_mask[k] = 1'b1;
            end
         end
         case (k)
            0: r.uses_ab = u;
            1: r.uses_bc = u;
            default: r.uses_ca = u;
         endcase
      end
      r.unique_edges = edge_count[UNIQUE_W-1:0];
      r.mesh_done    = f.last_face;
      if (f.last_face) edge_count = 0;
      return r;
   endfunction

   function automatic void check_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_val, act_val);
         errors++;
      end
   endfunction

   // drives one face beat; returns once it is accepted, leaving push high
   task automatic send_face(input logic [15:0] a, b, c, input logic last);
      face_type f;
      f = {a, b, c, last};
      @(negedge clock);
      while (!calm && $urandom_range(99) < 7) begin
         push = 1'b0;
         @(negedge clock);
      end
      push          = 1'b1;
      req_vertex_a  = a;
      req_vertex_b  = b;
      req_vertex_c  = c;
      req_last_face = last;
      forever begin
         @(posedge clock);
         if (!full) break;
      end
      pending_tallies.push_back(tally_face(f));
   endtask

   // receiver: random idling plus optional long hold-off
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles = hold_cycles - 1;
         pop = 1'b0;
      end else begin
         pop = calm || ($urandom_range(99) >= 7);
      end
   end

   always @(posedge clock) begin
      result_type e;
      if (!reset && pop && !empty) begin
         if (pending_tallies.size() == 0) begin
            $display("%0t: result beat with nothing expected", $time);
            errors++;
         end else begin
            e = pending_tallies.pop_front();
            check_field("unique_edges", e.unique_edges, rsp_unique_edges);
            check_field("new_edge_mask", e.new_edge_mask, rsp_new_edge_mask);
            check_field("uses_ab", e.uses_ab, rsp_uses_ab);
            check_field("uses_bc", e.uses_bc, rsp_uses_bc);
            check_field("uses_ca", e.uses_ca, rsp_uses_ca);
            check_field("table_full", e.table_full, rsp_table_full);
            check_field("mesh_done", e.mesh_done, rsp_mesh_done);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_mesh_edge_use_table NOT OK");
         $finish;
      end
   end

   task automatic test_directed();
      send_face(0, 1, 2, 0);
      send_face(2, 1, 0, 0);
      send_face(5, 5, 5, 0);
      send_face(0, 16'hFFFF, 16'hFFFF, 0);
      send_face(16'hFFFF, 0, 1, 0);
      send_face(16'hAAAA, 16'h5555, 16'hFFFF, 0);
      send_face(16'h5555, 16'hAAAA, 0, 0);
      send_face(1, 2, 3, 1);
      send_face(1, 2, 3, 1);
   endtask

   task automatic test_random_meshes();
      int sent, len, j, pool;
      logic [15:0] base;
      sent = 0;
      while (sent < 240) begin
         len  = $urandom_range(40, 1);
         base = 16'($urandom);
         pool = $urandom_range(30, 3);
         for (j = 0; j < len; j++) begin
            calm = (sent >= 80 && sent < 160);
            if ($urandom_range(9) == 0)
               send_face(16'($urandom), 16'($urandom), 16'($urandom), j == len-1);
            else
               send_face(16'(base + $urandom_range(pool)), 16'(base + $urandom_range(pool)),
                         16'(base + $urandom_range(pool)), j == len-1);
            sent++;
         end
      end
      calm = 1'b0;
   endtask

   task automatic test_backpressure();
      int j;
      hold_cycles = 300;
      for (j = 0; j < 12; j++)
         send_face(16'($urandom_range(8)), 16'($urandom_range(8)),
                   16'($urandom_range(8)), j == 11);
   endtask

   task automatic test_table_full();
      int j;
      for (j = 0; j < 343; j++) send_face(16'(3*j), 16'(3*j+1), 16'(3*j+2), 0);
      send_face(0, 1, 2, 0);
      send_face(4000, 4001, 1, 1);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random_meshes();
      test_backpressure();
      test_table_full();
      @(negedge clock);
      push = 1'b0;
      while (pending_tallies.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0) $display("tb_mesh_edge_use_table OK");
      else $display("tb_mesh_edge_use_table NOT OK");
      $finish;
   end
endmodule
